// ===== rtl/mvc_pkg.sv =====
`timescale 1ns / 1ps

package mvc_pkg;

    // Grid geometry and derived widths.
    localparam int GRID_SIZE = 128;
    localparam int CW        = $clog2(GRID_SIZE);
    localparam int DEPTH     = GRID_SIZE * GRID_SIZE;
    localparam int AW        = $clog2(DEPTH);

    // Field widths fixed by the interface.
    localparam int POS_W      = 7;
    localparam int CNT_W      = 16;
    localparam int SCALE_W    = 4;
    localparam int PEN_W      = 10;
    localparam int WGT_W      = CNT_W + SCALE_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_VISIT_SCALE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_PENALTY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_END_PENALTY = 2'd2;

    localparam logic [SCALE_W-1:0] VISIT_SCALE_RST  = 4'd5;
    localparam logic [PEN_W-1:0]   WALL_PEN_RST     = 10'd100;
    localparam logic [PEN_W-1:0]   DEAD_END_PEN_RST = 10'd100;

    // Compass headings.
    localparam logic [1:0] DIR_EAST  = 2'd0;
    localparam logic [1:0] DIR_NORTH = 2'd1;
    localparam logic [1:0] DIR_WEST  = 2'd2;
    localparam logic [1:0] DIR_SOUTH = 2'd3;

    // Move codes relative to the robot.
    localparam logic [1:0] MOVE_RIGHT = 2'd0;
    localparam logic [1:0] MOVE_FRONT = 2'd1;
    localparam logic [1:0] MOVE_LEFT  = 2'd2;
    localparam logic [1:0] MOVE_BACK  = 2'd3;

    typedef logic [CW-1:0]    coord_t;
    typedef logic [AW-1:0]    addr_t;
    typedef logic [CNT_W-1:0] count_t;
    typedef logic [WGT_W-1:0] weight_t;

    // A neighbor cell, already clamped; outside marks a step off the grid.
    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   outside;
    } cell_t;

    // What the weighing unit needs to know about one side.
    typedef struct packed {
        count_t count;
        logic   wall;
        logic   outside;
    } side_t;

    typedef struct packed {
        logic   en;
        addr_t  addr;
        count_t data;
    } wr_req_t;

    function automatic coord_t clamp_pos(logic [POS_W-1:0] p);
        if (int'(p) > GRID_SIZE - 1) begin
            return coord_t'(GRID_SIZE - 1);
        end
        return coord_t'(p);
    endfunction

    function automatic cell_t step_cell(coord_t x, coord_t y, logic [1:0] dir);
        cell_t c;
        c.x       = x;
        c.y       = y;
        c.outside = 1'b0;
        case (dir)
            DIR_EAST: begin
                if (x == coord_t'(GRID_SIZE - 1)) c.outside = 1'b1;
                else c.x = x + coord_t'(1);
            end
            DIR_NORTH: begin
                if (y == '0) c.outside = 1'b1;
                else c.y = y - coord_t'(1);
            end
            DIR_WEST: begin
                if (x == '0) c.outside = 1'b1;
                else c.x = x - coord_t'(1);
            end
            DIR_SOUTH: begin
                if (y == coord_t'(GRID_SIZE - 1)) c.outside = 1'b1;
                else c.y = y + coord_t'(1);
            end
            default: c.outside = 1'b1;
        endcase
        return c;
    endfunction

    // Cells are stored column-major: address = x * GRID_SIZE + y.
    function automatic addr_t cell_addr(coord_t x, coord_t y);
        addr_t xa;
        addr_t ya;
        xa = addr_t'(x);
        ya = addr_t'(y);
        return xa * addr_t'(GRID_SIZE) + ya;
    endfunction

    function automatic count_t sat_add(count_t c, logic [PEN_W-1:0] amt);
        logic [CNT_W:0] s;
        s = {1'b0, c} + (CNT_W + 1)'(amt);
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

endpackage

// ===== rtl/maze_visit_count_explorer.sv =====
`timescale 1ns / 1ps

// Maze explorer step over a GRID_SIZE x GRID_SIZE map of 16-bit visit counts
// held in one two-read, one-write memory. Each input word gives the robot's
// cell, heading and three wall flags; the block reads the counts of the right,
// front, left and back neighbors and of the current cell, weighs the three
// open directions, and answers with one output word (move, new cell, new
// heading) while it writes the updated counts back. After reset the block
// first runs a clearing pass that zeroes the map one entry per cycle, all
// GRID_SIZE * GRID_SIZE entries (16384 at the default size); s_tready
// stays low during that pass, while configuration writes are taken at any
// time. An item then runs through the memory sequence: two-port reads in
// ST_RD0, ST_RD1 and ST_RD2, the weight multiply in ST_MUL, and the decision
// and first write in ST_DEC. A back move into a different cell adds ST_WR2
// for the second write to the single write port. Items are handled one
// after another so each one sees the counts left by the previous one; a
// one-word input buffer and an output register let the next word be
// accepted and the last result wait while an item is at work.

module maze_visit_count_explorer import mvc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,

    // s_tdata: pos_x[6:0], pos_y[13:7], heading[15:14], wall_right[16],
    // wall_front[17], wall_left[18], zero pad [23:19].
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,

    // m_tdata: move_dir[1:0], new_x[8:2], new_y[15:9], new_heading[17:16],
    // zero pad [23:18].
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,

    // Register write: index 0 visit_scale, 1 wall_penalty, 2 dead_end_penalty.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RD0   = 3'd2;
    localparam logic [2:0] ST_RD1   = 3'd3;
    localparam logic [2:0] ST_RD2   = 3'd4;
    localparam logic [2:0] ST_MUL   = 3'd5;
    localparam logic [2:0] ST_DEC   = 3'd6;
    localparam logic [2:0] ST_WR2   = 3'd7;

    localparam logic [PEN_W-1:0] VISIT_STEP = PEN_W'(1);

    typedef struct packed {
        coord_t     x;
        coord_t     y;
        logic [1:0] heading;
        logic       wall_r;
        logic       wall_f;
        logic       wall_l;
    } item_t;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    addr_t              clr_addr_reg;
    logic               buf_valid_reg;
    item_t              buf_reg;
    item_t              work_reg;

    logic [SCALE_W-1:0] visit_scale_reg;
    logic [PEN_W-1:0]   wall_penalty_reg;
    logic [PEN_W-1:0]   dead_end_reg;

    count_t             cnt_r_reg;
    count_t             cnt_f_reg;
    count_t             cnt_l_reg;
    count_t             cnt_c_reg;
    count_t             cnt_b_reg;
    wr_req_t            wr2_reg;
    wr_req_t            wr2_next;

    logic               out_valid_reg;
    logic [1:0]         out_move_reg;
    logic [POS_W-1:0]   out_x_reg;
    logic [POS_W-1:0]   out_y_reg;
    logic [1:0]         out_heading_reg;

    logic               s_accept;
    logic               dec_go;
    logic               load_work;
    item_t              in_item;

    logic [1:0]         dir_r;
    logic [1:0]         dir_f;
    logic [1:0]         dir_l;
    logic [1:0]         dir_b;
    cell_t              nb_r;
    cell_t              nb_f;
    cell_t              nb_l;
    cell_t              nb_b;
    addr_t              addr_cur;
    addr_t              addr_r;
    addr_t              addr_f;
    addr_t              addr_l;
    addr_t              addr_b;

    addr_t              rd_addr_a;
    addr_t              rd_addr_b;
    count_t             rd_data_a;
    count_t             rd_data_b;
    wr_req_t            wr;
    wr_req_t            wr1;

    side_t              side_r;
    side_t              side_f;
    side_t              side_l;
    logic [1:0]         move_dir;

    cell_t              dest_cell;
    count_t             dest_cnt;
    logic [1:0]         dest_dir;
    count_t             cur_pen;

    // Unpack the input word; coordinates beyond the grid clamp to its edge.
    always_comb begin
        in_item.x       = clamp_pos(s_tdata[6:0]);
        in_item.y       = clamp_pos(s_tdata[13:7]);
        in_item.heading = s_tdata[15:14];
        in_item.wall_r  = s_tdata[16];
        in_item.wall_f  = s_tdata[17];
        in_item.wall_l  = s_tdata[18];
    end

    assign s_tready = (state_reg != ST_CLEAR) && !buf_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Neighbor geometry of the item at work.
    always_comb begin
        dir_r    = work_reg.heading + 2'd3;
        dir_f    = work_reg.heading;
        dir_l    = work_reg.heading + 2'd1;
        dir_b    = work_reg.heading + 2'd2;
        nb_r     = step_cell(work_reg.x, work_reg.y, dir_r);
        nb_f     = step_cell(work_reg.x, work_reg.y, dir_f);
        nb_l     = step_cell(work_reg.x, work_reg.y, dir_l);
        nb_b     = step_cell(work_reg.x, work_reg.y, dir_b);
        addr_cur = cell_addr(work_reg.x, work_reg.y);
        addr_r   = cell_addr(nb_r.x, nb_r.y);
        addr_f   = cell_addr(nb_f.x, nb_f.y);
        addr_l   = cell_addr(nb_l.x, nb_l.y);
        addr_b   = cell_addr(nb_b.x, nb_b.y);
    end

    // Read schedule: right and front, then left and current, then back.
    always_comb begin
        case (state_reg)
            ST_RD1: begin
                rd_addr_a = addr_l;
                rd_addr_b = addr_cur;
            end
            ST_RD2: begin
                rd_addr_a = addr_b;
                rd_addr_b = addr_cur;
            end
            default: begin
                rd_addr_a = addr_r;
                rd_addr_b = addr_f;
            end
        endcase
    end

    mvc_visit_ram u_ram (
        .aclk      (aclk),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .wr        (wr)
    );

    assign side_r = '{count: cnt_r_reg, wall: work_reg.wall_r, outside: nb_r.outside};
    assign side_f = '{count: cnt_f_reg, wall: work_reg.wall_f, outside: nb_f.outside};
    assign side_l = '{count: cnt_l_reg, wall: work_reg.wall_l, outside: nb_l.outside};

    // Weights are registered at the end of ST_MUL; the move is valid in ST_DEC.
    mvc_weigh u_weigh (
        .aclk         (aclk),
        .side_r       (side_r),
        .side_f       (side_f),
        .side_l       (side_l),
        .visit_scale  (visit_scale_reg),
        .wall_penalty (wall_penalty_reg),
        .move_dir     (move_dir)
    );

    // Destination and count updates. A step off the grid clamps back onto
    // the current cell, so its count is the one that gains the visit.
    always_comb begin
        case (move_dir)
            MOVE_RIGHT: begin
                dest_cell = nb_r;
                dest_cnt  = nb_r.outside ? cnt_c_reg : cnt_r_reg;
                dest_dir  = dir_r;
            end
            MOVE_FRONT: begin
                dest_cell = nb_f;
                dest_cnt  = nb_f.outside ? cnt_c_reg : cnt_f_reg;
                dest_dir  = dir_f;
            end
            MOVE_LEFT: begin
                dest_cell = nb_l;
                dest_cnt  = nb_l.outside ? cnt_c_reg : cnt_l_reg;
                dest_dir  = dir_l;
            end
            default: begin
                dest_cell = nb_b;
                dest_cnt  = nb_b.outside ? cnt_c_reg : cnt_b_reg;
                dest_dir  = dir_b;
            end
        endcase

        cur_pen  = sat_add(cnt_c_reg, dead_end_reg);
        wr1.en   = 1'b1;
        wr2_next = '{en: 1'b0, addr: addr_b, data: sat_add(cnt_b_reg, VISIT_STEP)};
        if (move_dir == MOVE_BACK) begin
            wr1.addr = addr_cur;
            if (nb_b.outside) begin
                // The robot stays put: penalty and visit land on one cell.
                wr1.data = sat_add(cur_pen, VISIT_STEP);
            end else begin
                wr1.data    = cur_pen;
                wr2_next.en = 1'b1;
            end
        end else begin
            wr1.addr = cell_addr(dest_cell.x, dest_cell.y);
            wr1.data = sat_add(dest_cnt, VISIT_STEP);
        end
    end

    assign dec_go = (state_reg == ST_DEC) && !(out_valid_reg && !m_tready);

    // Write port: clearing pass, first write at the decision, second write after.
    always_comb begin
        wr = '{en: 1'b0, addr: addr_cur, data: '0};
        case (state_reg)
            ST_CLEAR: wr = '{en: 1'b1, addr: clr_addr_reg, data: '0};
            ST_DEC:   if (dec_go) wr = wr1;
            ST_WR2:   wr = wr2_reg;
            default:  wr.en = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        load_work  = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == addr_t'(DEPTH - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (buf_valid_reg) begin
                    load_work  = 1'b1;
                    state_next = ST_RD0;
                end
            end
            ST_RD0:  state_next = ST_RD1;
            ST_RD1:  state_next = ST_RD2;
            ST_RD2:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_DEC;
            ST_DEC: begin
                if (dec_go) begin
                    if (wr2_next.en) begin
                        state_next = ST_WR2;
                    end else if (buf_valid_reg) begin
                        load_work  = 1'b1;
                        state_next = ST_RD0;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_WR2: begin
                if (buf_valid_reg) begin
                    load_work  = 1'b1;
                    state_next = ST_RD0;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            clr_addr_reg     <= '0;
            buf_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            visit_scale_reg  <= VISIT_SCALE_RST;
            wall_penalty_reg <= WALL_PEN_RST;
            dead_end_reg     <= DEAD_END_PEN_RST;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + addr_t'(1);
            end
            if (s_accept) begin
                buf_valid_reg <= 1'b1;
            end else if (load_work) begin
                buf_valid_reg <= 1'b0;
            end
            if (dec_go) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_VISIT_SCALE:      visit_scale_reg  <= cfg_data[SCALE_W-1:0];
                    REG_WALL_PENALTY:     wall_penalty_reg <= cfg_data[PEN_W-1:0];
                    REG_DEAD_END_PENALTY: dead_end_reg     <= cfg_data[PEN_W-1:0];
                    default:              dead_end_reg     <= dead_end_reg;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            buf_reg <= in_item;
        end
        if (load_work) begin
            work_reg <= buf_reg;
        end
        if (state_reg == ST_RD1) begin
            cnt_r_reg <= rd_data_a;
            cnt_f_reg <= rd_data_b;
        end
        if (state_reg == ST_RD2) begin
            cnt_l_reg <= rd_data_a;
            cnt_c_reg <= rd_data_b;
        end
        if (state_reg == ST_MUL) begin
            cnt_b_reg <= rd_data_a;
        end
        if (dec_go) begin
            wr2_reg         <= wr2_next;
            out_move_reg    <= move_dir;
            out_x_reg       <= POS_W'(dest_cell.x);
            out_y_reg       <= POS_W'(dest_cell.y);
            out_heading_reg <= dest_dir;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_heading_reg, out_y_reg, out_x_reg, out_move_reg};

endmodule

// ===== rtl/mvc_visit_ram.sv =====
`timescale 1ns / 1ps

module mvc_visit_ram import mvc_pkg::*; (
    input  logic    aclk,
    input  addr_t   rd_addr_a,
    input  addr_t   rd_addr_b,
    output count_t  rd_data_a,
    output count_t  rd_data_b,
    input  wr_req_t wr
);

    // Two read ports and one write port, read data registered.
    count_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== rtl/mvc_weigh.sv =====
`timescale 1ns / 1ps

module mvc_weigh import mvc_pkg::*; (
    input  logic               aclk,
    input  side_t              side_r,
    input  side_t              side_f,
    input  side_t              side_l,
    input  logic [SCALE_W-1:0] visit_scale,
    input  logic [PEN_W-1:0]   wall_penalty,
    output logic [1:0]         move_dir
);

    localparam logic [1:0] PREF_RIGHT = 2'd1;
    localparam logic [1:0] PREF_FRONT = 2'd2;
    localparam logic [1:0] PREF_LEFT  = 2'd3;

    weight_t wgt_r_reg;
    weight_t wgt_f_reg;
    weight_t wgt_l_reg;
    weight_t best;
    weight_t pen_w;
    logic [1:0] pick;

    // An off-grid side weighs as count zero and takes the wall penalty once.
    function automatic weight_t side_weight(side_t s, logic [SCALE_W-1:0] scale,
                                            logic [PEN_W-1:0] pen, logic [1:0] pref);
        count_t  c;
        weight_t w;
        c = s.outside ? '0 : s.count;
        w = weight_t'(c) * weight_t'(scale) + weight_t'(pref);
        if (s.wall || s.outside) begin
            w = w + weight_t'(pen);
        end
        return w;
    endfunction

    always_ff @(posedge aclk) begin
        wgt_r_reg <= side_weight(side_r, visit_scale, wall_penalty, PREF_RIGHT);
        wgt_f_reg <= side_weight(side_f, visit_scale, wall_penalty, PREF_FRONT);
        wgt_l_reg <= side_weight(side_l, visit_scale, wall_penalty, PREF_LEFT);
    end

    always_comb begin
        pen_w = weight_t'(wall_penalty);
        if (wgt_r_reg < wgt_f_reg) begin
            best = wgt_r_reg;
            pick = MOVE_RIGHT;
        end else begin
            best = wgt_f_reg;
            pick = MOVE_FRONT;
        end
        if (wgt_l_reg < best) begin
            pick = MOVE_LEFT;
        end
        if (wgt_r_reg > pen_w && wgt_f_reg > pen_w && wgt_l_reg > pen_w) begin
            pick = MOVE_BACK;
        end
        move_dir = pick;
    end

endmodule

// ===== rtl/mvc_checker.sv =====
`timescale 1ns / 1ps

module mvc_checker import mvc_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata
);

    // A result waiting on the sink keeps its word.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // The map clearing pass follows every reset, so no input is taken at once.
    a_clear_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_tready)
        else $error("input ready right after reset");

    // An accepted word fills the one-word buffer.
    a_buffer_full: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready with a full buffer");

    // Reset drops any pending result.
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind maze_visit_count_explorer mvc_checker u_mvc_checker (.*);
